>>> src/lnu_pkg.sv
// Shared types and constants for the LIF neuron state update block.
`timescale 1ns / 1ps
`default_nettype none
package lnu_pkg;

  localparam int DATA_W   = 32;
  localparam int IDX_W    = 10;
  localparam int ACTION_W = 2;
  localparam int DECAY_W  = 17;
  localparam int CFG_IDX_W = 1;

  // Threshold after reset: 1.0 in Q16.16
  localparam logic signed [DATA_W-1:0] THRESH_RESET = 32'sd65536;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_SPIKE = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_LOAD  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY  = 1'b0,
    CFG_THRESH = 1'b1
  } cfg_idx_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    action_t                  op;
    logic                     idx_ok;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] data;
  } cmd_t;

endpackage
`default_nettype wire

>>> src/lnu_front.sv
// Front end: accepts requests, checks the index range and forms queue commands.
`timescale 1ns / 1ps
`default_nettype none
module lnu_front #(
  parameter int NUM_INPUTS = 1024
) (
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lnu_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [lnu_pkg::IDX_W-1:0]       in_input_index,
  input  wire logic signed [lnu_pkg::DATA_W-1:0] in_data_value,
  input  wire logic                            q_full,
  output logic                                 push,
  output lnu_pkg::cmd_t                        push_cmd
);
  import lnu_pkg::*;

  logic idx_ok;

  // Index must fall inside the weight row
  assign idx_ok = ({{(32-IDX_W){1'b0}}, in_input_index} < 32'(NUM_INPUTS));

  assign in_ready = !q_full;

  // Weight writes outside the row are dropped here; all else is queued
  always_comb begin
    push_cmd.op     = action_t'(in_action);
    push_cmd.idx_ok = idx_ok;
    push_cmd.index  = in_input_index;
    push_cmd.data   = in_data_value;
    push = in_valid && in_ready && !((push_cmd.op == ACT_WRITE) && !idx_ok);
  end

endmodule
`default_nettype wire

>>> src/lnu_queue.sv
// Short command queue decoupling the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
module lnu_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lnu_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output lnu_pkg::cmd_t      q_cmd
);
  import lnu_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

>>> src/lnu_back.sv
// Back end: weight memory, step accumulator, membrane update and result register.
`timescale 1ns / 1ps
`default_nettype none
module lnu_back #(
  parameter int NUM_INPUTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire lnu_pkg::cmd_t                     q_cmd,
  output logic                                   pop,
  input  wire logic [lnu_pkg::DECAY_W-1:0]       decay,
  input  wire logic signed [lnu_pkg::DATA_W-1:0] thresh,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [lnu_pkg::DATA_W-1:0]      out_new_membrane,
  output logic                                   out_was_reset
);
  import lnu_pkg::*;

  localparam int AW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int DW = (FRAC_BITS + 1 > DECAY_W) ? FRAC_BITS + 1 : DECAY_W;
  localparam int PW = DATA_W + DW + 1;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  // Weight row, undefined until written
  logic signed [DATA_W-1:0] wmem [NUM_INPUTS];
  logic [AW-1:0]            addr;

  // Execute stage
  logic                     ex_v_r;
  cmd_t                     ex_cmd_r;
  logic signed [DATA_W-1:0] wt_r;

  // Finish stage (end of step only)
  logic                     fin_v_r;
  logic signed [PW-1:0]     keep_prod_r;
  logic signed [PW-1:0]     inject_prod_r;
  logic                     fired_r;

  // Neuron state
  logic signed [DATA_W-1:0] acc_r;
  logic signed [DATA_W-1:0] acc_nxt;
  logic signed [DATA_W-1:0] membrane_r;
  logic signed [DATA_W-1:0] membrane_nxt;

  // Result register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_mem_r;
  logic                     out_reset_r;

  logic                     busy;
  logic                     fin_fire;
  logic                     ex_step;
  logic [DW-1:0]            d_eff;
  logic [DW-1:0]            one_minus_d;
  logic signed [DATA_W-1:0] w_use;
  logic signed [DATA_W:0]   acc_sum;
  logic signed [PW-1:0]     keep_sh;
  logic signed [PW-1:0]     inject_sh;
  logic signed [PW:0]       total;

  assign addr = AW'(q_cmd.index);

  // Hold the queue while an end-of-step request is in flight
  assign ex_step  = ex_v_r && (ex_cmd_r.op == ACT_STEP);
  assign busy     = ex_step || fin_v_r;
  assign pop      = q_valid && !busy;
  assign fin_fire = fin_v_r && (!out_valid_r || out_ready);

  // Memory port: write on pop, registered read
  always_ff @(posedge clk) begin
    if (pop) begin
      if ((q_cmd.op == ACT_WRITE) && q_cmd.idx_ok) begin
        wmem[addr] <= q_cmd.data;
      end
      wt_r <= wmem[addr];
    end
  end

  // Decay clamped to 1.0
  always_comb begin
    d_eff       = (DW'(decay) > ONE) ? ONE : DW'(decay);
    one_minus_d = ONE - d_eff;
  end

  // Saturating accumulate
  always_comb begin
    w_use   = ex_cmd_r.idx_ok ? wt_r : '0;
    acc_sum = $signed({acc_r[DATA_W-1], acc_r}) + $signed({w_use[DATA_W-1], w_use});
    if (acc_sum[DATA_W] != acc_sum[DATA_W-1]) begin
      acc_nxt = acc_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      acc_nxt = acc_sum[DATA_W-1:0];
    end
  end

  // Truncate both products (arithmetic shift), drop the kept part on a fire, add, saturate
  always_comb begin
    keep_sh   = keep_prod_r >>> FRAC_BITS;
    if (fired_r) begin
      keep_sh = '0;
    end
    inject_sh = inject_prod_r >>> FRAC_BITS;
    total     = $signed({keep_sh[PW-1], keep_sh}) + $signed({inject_sh[PW-1], inject_sh});
    if (total[PW:DATA_W-1] != {(PW-DATA_W+2){total[PW]}}) begin
      membrane_nxt = total[PW] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      membrane_nxt = total[DATA_W-1:0];
    end
  end

  // Pipeline control and neuron state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r      <= 1'b0;
      fin_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      membrane_r  <= '0;
    end else begin
      ex_v_r <= pop;
      if (ex_v_r) begin
        unique case (ex_cmd_r.op)
          ACT_SPIKE: acc_r      <= acc_nxt;
          ACT_LOAD:  membrane_r <= ex_cmd_r.data;
          ACT_STEP:  fin_v_r    <= 1'b1;
          default:   ;
        endcase
      end
      if (fin_fire) begin
        fin_v_r     <= 1'b0;
        acc_r       <= '0;
        membrane_r  <= membrane_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      ex_cmd_r <= q_cmd;
    end
    if (ex_step) begin
      keep_prod_r   <= $signed({1'b0, d_eff}) * membrane_r;
      inject_prod_r <= $signed({1'b0, one_minus_d}) * acc_r;
      fired_r       <= (membrane_r > thresh);
    end
    if (fin_fire) begin
      out_mem_r   <= membrane_nxt;
      out_reset_r <= fired_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_membrane = out_mem_r;
  assign out_was_reset    = out_reset_r;

`ifndef NO_ASSERTIONS
  a_step_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ex_step |=> (fin_v_r && !ex_v_r))
    else $error("end of step did not move alone into finish stage");
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |=> (acc_r == '0))
    else $error("accumulator not cleared after end of step");
`endif

endmodule
`default_nettype wire

>>> src/lif_neuron_state_update.sv
// Top level of the LIF neuron state update block: config registers and unit wiring.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | request   | in_valid / in_ready  | action, input_index, data_value
//   out_    | result    | out_valid / out_ready| new_membrane, was_reset
//   cfg_    | write     | cfg_we               | cfg_index, cfg_wdata
//
// Weight writes, spikes and membrane loads issue one per cycle from the queue
// while no end of step is in flight. An end of step blocks issue while it is in the
// execute and finish stages (multiply, finish); its result then goes to the result register.
// Weight reads use one registered memory port; a spike adds its weight in the cycle after the read.
// Reset is synchronous, active low; the weight memory is not cleared.
// A full result register stalls the finish stage, then the queue, then in_ready.
`timescale 1ns / 1ps
`default_nettype none
module lif_neuron_state_update #(
  parameter int NUM_INPUTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [lnu_pkg::ACTION_W-1:0]        in_action,
  input  wire logic [lnu_pkg::IDX_W-1:0]           in_input_index,
  input  wire logic signed [lnu_pkg::DATA_W-1:0]   in_data_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [lnu_pkg::DATA_W-1:0]        out_new_membrane,
  output logic                                     out_was_reset,
  input  wire logic                                cfg_we,
  input  wire logic [lnu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lnu_pkg::DATA_W-1:0]          cfg_wdata
);
  import lnu_pkg::*;

  logic [DECAY_W-1:0]       decay_r;
  logic signed [DATA_W-1:0] thresh_r;
  logic                     q_full;
  logic                     push;
  cmd_t                     push_cmd;
  logic                     pop;
  logic                     q_valid;
  cmd_t                     q_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= '0;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DECAY:  decay_r  <= cfg_wdata[DECAY_W-1:0];
        CFG_THRESH: thresh_r <= $signed(cfg_wdata);
        default:    ;
      endcase
    end
  end

  lnu_front #(
    .NUM_INPUTS(NUM_INPUTS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_input_index (in_input_index),
    .in_data_value  (in_data_value),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  lnu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  lnu_back #(
    .NUM_INPUTS(NUM_INPUTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .pop              (pop),
    .decay            (decay_r),
    .thresh           (thresh_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_membrane (out_new_membrane),
    .out_was_reset    (out_was_reset)
  );

endmodule
`default_nettype wire

>>> bench/lnu_checker.sv
// Checker for the LIF neuron block: mirrors the neuron state and compares every membrane update.
`timescale 1ns / 1ps
module lnu_checker #(
  parameter int NUM_INPUTS = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [lnu_pkg::ACTION_W-1:0]          in_action,
  input  logic [lnu_pkg::IDX_W-1:0]             in_input_index,
  input  logic signed [lnu_pkg::DATA_W-1:0]     in_data_value,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [lnu_pkg::DATA_W-1:0]     out_new_membrane,
  input  logic                                  out_was_reset,
  input  logic                                  cfg_we,
  input  logic [lnu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lnu_pkg::DATA_W-1:0]            cfg_wdata,
  output int                                    error_count,
  output int                                    pending_updates,
  output int                                    updates_checked
);
  import lnu_pkg::*;

  localparam longint Q_ONE     = longint'(1) << FRAC_BITS;
  localparam longint S32_MAX_L = 64'sd2147483647;
  localparam longint S32_MIN_L = -64'sd2147483648;
  localparam int     MAX_PRINTS = 40;

  typedef struct {
    logic signed [DATA_W-1:0] membrane;
    logic                     fired;
  } membrane_update_t;

  // Mirrored neuron state and registers
  logic signed [DATA_W-1:0] syn_weight [NUM_INPUTS];
  logic signed [DATA_W-1:0] membrane_q;
  logic signed [DATA_W-1:0] step_acc;
  logic signed [DATA_W-1:0] threshold_q;
  logic [DECAY_W-1:0]       decay_q;
  membrane_update_t         expected_updates [$];

  function automatic logic signed [DATA_W-1:0] clamp_s32(longint v);
    if (v > S32_MAX_L) return 32'sh7fffffff;
    if (v < S32_MIN_L) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Apply one accepted request to the mirrored neuron; a step queues its update
  task automatic integrate_request(action_t act, logic [IDX_W-1:0] idx,
                                   logic signed [DATA_W-1:0] data);
    longint acc_sum;
    longint d;
    longint m;
    longint a;
    longint keep;
    longint inject;
    logic fired;
    membrane_update_t upd;
    case (act)
      ACT_WRITE: begin
        if (idx < NUM_INPUTS) syn_weight[idx] = data;
      end
      ACT_SPIKE: begin
        acc_sum = longint'(step_acc);
        if (idx < NUM_INPUTS) acc_sum += longint'(syn_weight[idx]);
        step_acc = clamp_s32(acc_sum);
      end
      ACT_LOAD: begin
        membrane_q = data;
      end
      default: begin
        // decay above 1.0 behaves as exactly 1.0
        d = longint'(decay_q);
        if (d > Q_ONE) d = Q_ONE;
        m = longint'(membrane_q);
        a = longint'(step_acc);
        fired = membrane_q > threshold_q;
        // products truncate toward minus infinity
        inject = ((Q_ONE - d) * a) >>> FRAC_BITS;
        keep = fired ? 64'sd0 : ((d * m) >>> FRAC_BITS);
        membrane_q = clamp_s32(keep + inject);
        step_acc = '0;
        upd.membrane = membrane_q;
        upd.fired = fired;
        expected_updates.push_back(upd);
      end
    endcase
  endtask

  // Watch config writes, results and requests at each rising edge
  always @(posedge clk) begin
    membrane_update_t exp_upd;
    if (!rst_n) begin
      membrane_q = '0;
      step_acc = '0;
      decay_q = '0;
      threshold_q = THRESH_RESET;
      expected_updates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DECAY:  decay_q = cfg_wdata[DECAY_W-1:0];
          CFG_THRESH: threshold_q = cfg_wdata;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          report_mismatch($sformatf("update %0d / reset %0b with nothing pending",
                                    out_new_membrane, out_was_reset));
        end else begin
          exp_upd = expected_updates.pop_front();
          if (out_new_membrane !== exp_upd.membrane)
            report_mismatch($sformatf("new_membrane got %0d expected %0d",
                                      out_new_membrane, exp_upd.membrane));
          if (out_was_reset !== exp_upd.fired)
            report_mismatch($sformatf("was_reset got %b expected %b",
                                      out_was_reset, exp_upd.fired));
          updates_checked++;
        end
      end
      if (in_valid && in_ready)
        integrate_request(action_t'(in_action), in_input_index, in_data_value);
    end
    pending_updates = expected_updates.size();
  end

endmodule

>>> bench/testbench.sv
// Top of the LIF neuron bench: clock, reset, request and result traffic, config phases, verdict.
`timescale 1ns / 1ps
module testbench;
  import lnu_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_REQUESTS = 280;
  localparam int NUM_INPUTS     = 1024;
  localparam int NUM_IDX        = 1 << IDX_W;

  localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sd65536;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;
  localparam logic [DECAY_W-1:0] DECAY_ZERO = 17'd0;
  localparam logic [DECAY_W-1:0] DECAY_HALF = 17'd32768;
  localparam logic [DECAY_W-1:0] DECAY_ONE  = 17'd65536;
  localparam logic [DECAY_W-1:0] DECAY_TOP  = 17'h1ffff;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACTION_W-1:0]      in_action;
  logic [IDX_W-1:0]         in_input_index;
  logic signed [DATA_W-1:0] in_data_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_new_membrane;
  logic                     out_was_reset;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;

  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_request;
  int   requests_sent;
  int   settings_used;
  int   written_idx [$];
  int   error_count;
  int   pending_updates;
  int   updates_checked;

  always #(CLK_PERIOD / 2) clk = ~clk;

  lif_neuron_state_update #(
    .NUM_INPUTS(NUM_INPUTS),
    .FRAC_BITS (16)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_input_index  (in_input_index),
    .in_data_value   (in_data_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_membrane(out_new_membrane),
    .out_was_reset   (out_was_reset),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  lnu_checker #(
    .NUM_INPUTS(NUM_INPUTS),
    .FRAC_BITS (16)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_input_index  (in_input_index),
    .in_data_value   (in_data_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_membrane(out_new_membrane),
    .out_was_reset   (out_was_reset),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .error_count     (error_count),
    .pending_updates (pending_updates),
    .updates_checked (updates_checked)
  );

  // Mix of full-range, small and extreme Q16.16 values
  function automatic logic signed [DATA_W-1:0] random_q16();
    int v;
    v = $urandom_range(0, 262144);
    case ($urandom_range(3))
      0: return $urandom;
      1: return v;
      2: return -v;
      default: return ($urandom_range(1) == 1) ? S32_MAX : S32_MIN;
    endcase
  endfunction

  // Spikes only hit weights that were written earlier
  function automatic logic [IDX_W-1:0] pick_written();
    return IDX_W'(written_idx[$urandom_range(written_idx.size() - 1)]);
  endfunction

  // Offer one request; valid stays high until it is taken
  task automatic send_request(action_t act, logic [IDX_W-1:0] idx,
                              logic signed [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_input_index <= idx;
    in_data_value <= data;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (act == ACT_WRITE) written_idx.push_back(int'(idx));
  endtask

  // Well-formed time step: some weight writes, maybe a load, spikes, then the step
  task automatic send_time_step();
    int n_writes;
    int n_spikes;
    n_writes = $urandom_range(3);
    n_spikes = $urandom_range(1, 8);
    repeat (n_writes)
      send_request(ACT_WRITE, IDX_W'($urandom_range(NUM_IDX - 1)), random_q16());
    if ($urandom_range(3) == 0)
      send_request(ACT_LOAD, IDX_W'($urandom_range(NUM_IDX - 1)), random_q16());
    repeat (n_spikes) send_request(ACT_SPIKE, pick_written(), $urandom);
    send_request(ACT_STEP, IDX_W'($urandom_range(NUM_IDX - 1)), $urandom);
  endtask

  // Any single request, e.g. a bare step or a lone load
  task automatic send_noise();
    action_t act;
    act = action_t'($urandom_range(3));
    if (act == ACT_SPIKE) send_request(act, pick_written(), $urandom);
    else send_request(act, IDX_W'($urandom_range(NUM_IDX - 1)), random_q16());
  endtask

  // Drain, let the pipeline settle, then write both registers
  task automatic set_config(logic [DECAY_W-1:0] decay, logic signed [DATA_W-1:0] thresh);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_updates != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DECAY;
    cfg_wdata <= {15'($urandom), decay};
    @(negedge clk);
    cfg_index <= CFG_THRESH;
    cfg_wdata <= thresh;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Result side: random stalls, plus one long hold-off when asked
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int phase_start;
    in_valid = 1'b0;
    in_action = ACT_WRITE;
    in_input_index = '0;
    in_data_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_DECAY;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    requests_sent = 0;
    settings_used = 1;
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset config (decay 0, threshold 1.0), saturation both ways
    send_request(ACT_WRITE, IDX_W'(0), S32_MAX);
    send_request(ACT_WRITE, IDX_W'(NUM_IDX - 1), S32_MIN);
    send_request(ACT_WRITE, IDX_W'(1), Q_ONE);
    send_request(ACT_WRITE, IDX_W'(2), -32'sd1);
    send_request(ACT_SPIKE, IDX_W'(0), '0);
    send_request(ACT_SPIKE, IDX_W'(0), '1);
    send_request(ACT_STEP, IDX_W'(0), '0);            // accumulator pinned at max
    send_request(ACT_STEP, IDX_W'(NUM_IDX - 1), '1);  // old value above threshold: fires
    send_request(ACT_SPIKE, IDX_W'(NUM_IDX - 1), '0);
    send_request(ACT_SPIKE, IDX_W'(NUM_IDX - 1), '0);
    send_request(ACT_SPIKE, IDX_W'(2), '0);           // stays pinned at min
    send_request(ACT_STEP, IDX_W'(0), '0);
    send_request(ACT_LOAD, IDX_W'(0), S32_MAX);
    send_request(ACT_SPIKE, IDX_W'(1), '0);
    send_request(ACT_STEP, IDX_W'(0), '0);
    send_request(ACT_LOAD, IDX_W'(0), Q_ONE);         // equal to threshold: no fire
    send_request(ACT_STEP, IDX_W'(0), '0);
    send_request(ACT_LOAD, IDX_W'(0), Q_ONE + 1);
    send_request(ACT_STEP, IDX_W'(0), '0);

    // Full decay, lowest threshold
    set_config(DECAY_ONE, S32_MIN);
    send_request(ACT_LOAD, IDX_W'(0), S32_MIN);
    send_request(ACT_STEP, IDX_W'(0), '0);

    // Decay above one, highest threshold
    set_config(DECAY_TOP, S32_MAX);
    send_request(ACT_LOAD, IDX_W'(0), S32_MAX);
    send_request(ACT_SPIKE, IDX_W'(1), '0);
    send_request(ACT_STEP, IDX_W'(0), '0);

    // Random phases, each with a setting and an idle pattern; the first and last use no idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(DECAY_HALF, $urandom);
        1: set_config(DECAY_ZERO, S32_MAX);
        2: set_config(DECAY_ONE, S32_MIN);
        3: set_config(DECAY_W'($urandom_range(DECAY_TOP)), $urandom);
        4: set_config(DECAY_TOP, Q_ONE);
        default: set_config(DECAY_W'($urandom_range(DECAY_ONE)), random_q16());
      endcase
      case (p)
        1: begin send_idle_pct = 59; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 59; end
        3: begin send_idle_pct = 8; recv_stall_pct = 8; end
        4: begin send_idle_pct = 59; recv_stall_pct = 59; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // back-pressure: receiver holds off while requests keep coming
      if (p == 0) hold_request = 1'b1;
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_REQUESTS) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_time_step();
      end
    end

    // Wind down
    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_updates != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run: %0d requests, %0d membrane updates checked, %0d register settings.",
             requests_sent, updates_checked, settings_used);
    $display("Covered saturation, fire/no-fire, decay 0 to above 1.0, idle mixes, hold-off.");
    if (pending_updates != 0)
      $display("%0d expected membrane updates never arrived", pending_updates);
    if (error_count == 0 && pending_updates == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
